[rtl/sli_pkg.sv]
// Package for the line intersection block: payload structs and fixed widths.
// No dependencies; used by sli_div and segment_intersection_2d_top.
`default_nettype none
package sli_pkg;

    localparam int COORD_W = 16;
    localparam int OUT_W   = 32;

    localparam logic signed [OUT_W-1:0] Q_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] Q_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
    } t_in;

    typedef struct packed {
        logic                    intersects;
        logic                    on_both;
        logic signed [OUT_W-1:0] ix;
        logic signed [OUT_W-1:0] iy;
        logic                    saturated;
    } t_out;

endpackage
`default_nettype wire

[rtl/sli_div.sv]
// Pipelined restoring divider, two numerators over one shared divisor.
// One quotient bit per stage; depends on sli_pkg for the output width.
`default_nettype none
module sli_div #(
    parameter int NW     = 51,
    parameter int DW     = 35,
    parameter int FB     = 8,
    parameter int SIDE_W = 65
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire signed [NW-1:0] i_nx,
    input  wire signed [NW-1:0] i_ny,
    input  wire signed [DW-1:0] i_den,
    input  wire [SIDE_W-1:0]    i_side,
    output logic                o_valid,
    output logic [31:0]         o_qx,
    output logic                o_ovf_x,
    output logic                o_neg_x,
    output logic [31:0]         o_qy,
    output logic                o_ovf_y,
    output logic                o_neg_y,
    output logic [SIDE_W-1:0]   o_side
);
    import sli_pkg::*;

    localparam int MW = NW + FB;
    localparam int RW = DW + 1;

    logic              r_v    [0:MW];
    logic [MW-1:0]     r_nx   [0:MW];
    logic [MW-1:0]     r_ny   [0:MW];
    logic [DW-1:0]     r_d    [0:MW];
    logic [RW-1:0]     r_rx   [0:MW];
    logic [RW-1:0]     r_ry   [0:MW];
    logic [OUT_W-1:0]  r_qx   [0:MW];
    logic [OUT_W-1:0]  r_qy   [0:MW];
    logic              r_ox   [0:MW];
    logic              r_oy   [0:MW];
    logic              r_sx   [0:MW];
    logic              r_sy   [0:MW];
    logic [SIDE_W-1:0] r_side [0:MW];

    logic [RW:0]       n_stx  [0:MW-1];
    logic [RW:0]       n_sty  [0:MW-1];
    logic [NW-1:0]     n_mx;
    logic [NW-1:0]     n_my;
    logic [DW-1:0]     n_md;

    function automatic logic [RW:0] f_step(logic [RW-1:0] rem, logic b, logic [DW-1:0] d);
        logic [RW-1:0] t;
        logic [RW-1:0] dd;
        t  = {rem[DW-1:0], b};
        dd = RW'(d);
        if (t >= dd) begin
            return {1'b1, t - dd};
        end else begin
            return {1'b0, t};
        end
    endfunction

    // take magnitudes on entry
    always_comb begin
        n_mx = i_nx[NW-1] ? NW'(-i_nx) : NW'(i_nx);
        n_my = i_ny[NW-1] ? NW'(-i_ny) : NW'(i_ny);
        n_md = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    end

    always_comb begin
        for (int s = 0; s < MW; s++) begin
            n_stx[s] = f_step(r_rx[s], r_nx[s][MW-1-s], r_d[s]);
            n_sty[s] = f_step(r_ry[s], r_ny[s][MW-1-s], r_d[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= MW; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int s = 0; s < MW; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx[0]   <= MW'(n_mx) << FB;
        r_ny[0]   <= MW'(n_my) << FB;
        r_d[0]    <= n_md;
        r_rx[0]   <= '0;
        r_ry[0]   <= '0;
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
        r_ox[0]   <= 1'b0;
        r_oy[0]   <= 1'b0;
        r_sx[0]   <= i_nx[NW-1] ^ i_den[DW-1];
        r_sy[0]   <= i_ny[NW-1] ^ i_den[DW-1];
        r_side[0] <= i_side;
        for (int s = 0; s < MW; s++) begin
            r_nx[s+1]   <= r_nx[s];
            r_ny[s+1]   <= r_ny[s];
            r_d[s+1]    <= r_d[s];
            r_rx[s+1]   <= n_stx[s][RW-1:0];
            r_ry[s+1]   <= n_sty[s][RW-1:0];
            r_qx[s+1]   <= {r_qx[s][OUT_W-2:0], n_stx[s][RW]};
            r_qy[s+1]   <= {r_qy[s][OUT_W-2:0], n_sty[s][RW]};
            r_ox[s+1]   <= r_ox[s] | r_qx[s][OUT_W-1];
            r_oy[s+1]   <= r_oy[s] | r_qy[s][OUT_W-1];
            r_sx[s+1]   <= r_sx[s];
            r_sy[s+1]   <= r_sy[s];
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid = r_v[MW];
    assign o_qx    = r_qx[MW];
    assign o_ovf_x = r_ox[MW];
    assign o_neg_x = r_sx[MW];
    assign o_qy    = r_qy[MW];
    assign o_ovf_y = r_oy[MW];
    assign o_neg_y = r_sy[MW];
    assign o_side  = r_side[MW];

endmodule
`default_nettype wire

[rtl/segment_intersection_2d_top.sv]
// Line/line intersection in 2D: five arithmetic stages, pipelined divider, output stage.
// Throughput: one transfer per cycle; busy is never raised, the result side cannot stall.
// Reset (synchronous, active low) clears only the valid bits; payload flops keep no reset.
// Depends on sli_pkg and sli_div.
`default_nettype none
module segment_intersection_2d_top #(
    parameter int FRAC_BITS = 8
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  sli_pkg::t_in   i_data,
    output logic           o_valid,
    output sli_pkg::t_out  o_res
);
    import sli_pkg::*;

    localparam int CW  = COORD_W;
    localparam int EW  = CW + 1;          // edge vector component
    localparam int PW  = 2 * CW + 1;      // cross term pre/post
    localparam int DW  = 2 * EW + 1;      // determinant
    localparam int MPW = PW + EW;         // pre*e product
    localparam int NW  = MPW + 1;         // numerator
    localparam int SW  = 4 * CW + 1;      // sideband: box bounds + parallel flag
    localparam int BW  = ((CW + FRAC_BITS) > OUT_W ? (CW + FRAC_BITS) : OUT_W) + 1;

    // stage 1: edge vectors and box overlap bounds
    logic                 r1_v;
    t_in                  r1_p;
    logic signed [EW-1:0] r1_e1x, r1_e1y, r1_e2x, r1_e2y;
    logic signed [CW-1:0] r1_lox, r1_hix, r1_loy, r1_hiy;

    // stage 2: products
    logic                     r2_v;
    logic signed [2*EW-1:0]   r2_pd1, r2_pd2;
    logic signed [2*CW-1:0]   r2_pa, r2_pb, r2_pc, r2_pe;
    logic signed [EW-1:0]     r2_e1x, r2_e1y, r2_e2x, r2_e2y;
    logic signed [CW-1:0]     r2_lox, r2_hix, r2_loy, r2_hiy;

    // stage 3: determinant and cross terms
    logic                 r3_v;
    logic signed [DW-1:0] r3_den;
    logic signed [PW-1:0] r3_pre, r3_post;
    logic signed [EW-1:0] r3_e1x, r3_e1y, r3_e2x, r3_e2y;
    logic signed [CW-1:0] r3_lox, r3_hix, r3_loy, r3_hiy;

    // stage 4: numerator products
    logic                  r4_v;
    logic signed [DW-1:0]  r4_den;
    logic signed [MPW-1:0] r4_m1, r4_m2, r4_m3, r4_m4;
    logic signed [CW-1:0]  r4_lox, r4_hix, r4_loy, r4_hiy;

    // stage 5: numerators
    logic                 r5_v;
    logic signed [DW-1:0] r5_den;
    logic signed [NW-1:0] r5_nx, r5_ny;
    logic [SW-1:0]        r5_side;

    logic              d_v, d_ox, d_sx, d_oy, d_sy;
    logic [OUT_W-1:0]  d_qx, d_qy;
    logic [SW-1:0]     d_side;

    logic signed [CW-1:0] n_min_ab_x, n_max_ab_x, n_min_cd_x, n_max_cd_x;
    logic signed [CW-1:0] n_min_ab_y, n_max_ab_y, n_min_cd_y, n_max_cd_y;

    logic                    n_zero, n_satx, n_saty;
    logic signed [OUT_W-1:0] n_px, n_py;
    logic signed [CW-1:0]    n_lox, n_hix, n_loy, n_hiy;
    logic signed [BW-1:0]    n_spx, n_spy, n_slox, n_shix, n_sloy, n_shiy;
    logic                    n_in;

    logic  r_v;
    t_out  r_res;

    assign busy = 1'b0;

    // overlap of the two bounding boxes
    always_comb begin
        n_min_ab_x = (i_data.ax < i_data.bx) ? i_data.ax : i_data.bx;
        n_max_ab_x = (i_data.ax < i_data.bx) ? i_data.bx : i_data.ax;
        n_min_cd_x = (i_data.cx < i_data.dx) ? i_data.cx : i_data.dx;
        n_max_cd_x = (i_data.cx < i_data.dx) ? i_data.dx : i_data.cx;
        n_min_ab_y = (i_data.ay < i_data.by_coord) ? i_data.ay : i_data.by_coord;
        n_max_ab_y = (i_data.ay < i_data.by_coord) ? i_data.by_coord : i_data.ay;
        n_min_cd_y = (i_data.cy < i_data.dy) ? i_data.cy : i_data.dy;
        n_max_cd_y = (i_data.cy < i_data.dy) ? i_data.dy : i_data.cy;
    end

    // advance valid bits every cycle; nothing ever stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p   <= i_data;
        r1_e1x <= EW'(i_data.ax) - EW'(i_data.bx);
        r1_e1y <= EW'(i_data.ay) - EW'(i_data.by_coord);
        r1_e2x <= EW'(i_data.cx) - EW'(i_data.dx);
        r1_e2y <= EW'(i_data.cy) - EW'(i_data.dy);
        r1_lox <= (n_min_ab_x > n_min_cd_x) ? n_min_ab_x : n_min_cd_x;
        r1_hix <= (n_max_ab_x < n_max_cd_x) ? n_max_ab_x : n_max_cd_x;
        r1_loy <= (n_min_ab_y > n_min_cd_y) ? n_min_ab_y : n_min_cd_y;
        r1_hiy <= (n_max_ab_y < n_max_cd_y) ? n_max_ab_y : n_max_cd_y;

        r2_pd1 <= (2*EW)'(r1_e1x) * (2*EW)'(r1_e2y);
        r2_pd2 <= (2*EW)'(r1_e1y) * (2*EW)'(r1_e2x);
        r2_pa  <= (2*CW)'(r1_p.ax) * (2*CW)'(r1_p.by_coord);
        r2_pb  <= (2*CW)'(r1_p.ay) * (2*CW)'(r1_p.bx);
        r2_pc  <= (2*CW)'(r1_p.cx) * (2*CW)'(r1_p.dy);
        r2_pe  <= (2*CW)'(r1_p.cy) * (2*CW)'(r1_p.dx);
        r2_e1x <= r1_e1x;
        r2_e1y <= r1_e1y;
        r2_e2x <= r1_e2x;
        r2_e2y <= r1_e2y;
        r2_lox <= r1_lox;
        r2_hix <= r1_hix;
        r2_loy <= r1_loy;
        r2_hiy <= r1_hiy;

        r3_den  <= DW'(r2_pd1) - DW'(r2_pd2);
        r3_pre  <= PW'(r2_pa) - PW'(r2_pb);
        r3_post <= PW'(r2_pc) - PW'(r2_pe);
        r3_e1x  <= r2_e1x;
        r3_e1y  <= r2_e1y;
        r3_e2x  <= r2_e2x;
        r3_e2y  <= r2_e2y;
        r3_lox  <= r2_lox;
        r3_hix  <= r2_hix;
        r3_loy  <= r2_loy;
        r3_hiy  <= r2_hiy;

        r4_den <= r3_den;
        r4_m1  <= MPW'(r3_pre) * MPW'(r3_e2x);
        r4_m2  <= MPW'(r3_e1x) * MPW'(r3_post);
        r4_m3  <= MPW'(r3_pre) * MPW'(r3_e2y);
        r4_m4  <= MPW'(r3_e1y) * MPW'(r3_post);
        r4_lox <= r3_lox;
        r4_hix <= r3_hix;
        r4_loy <= r3_loy;
        r4_hiy <= r3_hiy;

        r5_den  <= r4_den;
        r5_nx   <= NW'(r4_m1) - NW'(r4_m2);
        r5_ny   <= NW'(r4_m3) - NW'(r4_m4);
        r5_side <= {(r4_den == '0), r4_lox, r4_hix, r4_loy, r4_hiy};
    end

    sli_div #(
        .NW     (NW),
        .DW     (DW),
        .FB     (FRAC_BITS),
        .SIDE_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_v),
        .i_nx    (r5_nx),
        .i_ny    (r5_ny),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (d_v),
        .o_qx    (d_qx),
        .o_ovf_x (d_ox),
        .o_neg_x (d_sx),
        .o_qy    (d_qy),
        .o_ovf_y (d_oy),
        .o_neg_y (d_sy),
        .o_side  (d_side)
    );

    // clamp the quotients, apply sign, then test against the box overlap
    always_comb begin
        {n_zero, n_lox, n_hix, n_loy, n_hiy} = d_side;
        if (d_sx) begin
            n_satx = d_ox | (d_qx[OUT_W-1] & (|d_qx[OUT_W-2:0]));
            n_px   = n_satx ? Q_MIN : -$signed(d_qx);
        end else begin
            n_satx = d_ox | d_qx[OUT_W-1];
            n_px   = n_satx ? Q_MAX : $signed(d_qx);
        end
        if (d_sy) begin
            n_saty = d_oy | (d_qy[OUT_W-1] & (|d_qy[OUT_W-2:0]));
            n_py   = n_saty ? Q_MIN : -$signed(d_qy);
        end else begin
            n_saty = d_oy | d_qy[OUT_W-1];
            n_py   = n_saty ? Q_MAX : $signed(d_qy);
        end
        n_spx  = BW'(n_px);
        n_spy  = BW'(n_py);
        n_slox = BW'(n_lox) <<< FRAC_BITS;
        n_shix = BW'(n_hix) <<< FRAC_BITS;
        n_sloy = BW'(n_loy) <<< FRAC_BITS;
        n_shiy = BW'(n_hiy) <<< FRAC_BITS;
        n_in   = (n_spx >= n_slox) && (n_spx <= n_shix) &&
                 (n_spy >= n_sloy) && (n_spy <= n_shiy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= d_v;
        end
    end

    // drop everything to zero for parallel lines
    always_ff @(posedge i_clk) begin
        r_res.intersects <= ~n_zero;
        r_res.on_both    <= ~n_zero & n_in;
        r_res.ix         <= n_zero ? '0 : n_px;
        r_res.iy         <= n_zero ? '0 : n_py;
        r_res.saturated  <= ~n_zero & (n_satx | n_saty);
    end

    assign o_valid = r_v;
    assign o_res   = r_res;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.intersects) |->
        (o_res.ix == '0 && o_res.iy == '0 && !o_res.on_both && !o_res.saturated))
        else $error("parallel result not cleared");

    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.saturated) |->
        (o_res.ix == Q_MAX || o_res.ix == Q_MIN || o_res.iy == Q_MAX || o_res.iy == Q_MIN))
        else $error("saturation without clamped coordinate");

endmodule
`default_nettype wire
